// ===== design/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared types and constants for the periodic task scheduler core.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Margin added to every period when ranking tasks for the next check.
    localparam logic [31:0] SAFETY_MARGIN_MS = 32'd100000;
    // Last-fired time given to a newly added task.
    localparam logic [31:0] INITIAL_LAST_MS  = 32'd0;

    // Kinds of input request, carried on tuser.
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Width of one task entry: period in the high half, last-fired time low.
    localparam int ENTRY_W = 64;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_SPARE = 5'b10000
    } t_state;

endpackage

// ===== design/pts_ram.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler RAM
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/periodic_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler core
// Table of periodic tasks held in one RAM; add and tick requests in, one
// result per request out.
// ----------------------------------------------------------------------------
// An add request with room writes the task to the next free entry in the
// accept cycle and then goes to the result. A tick on an empty table goes
// straight to the result, and a tick whose selected task is not due takes
// one RAM read and one check. A tick that fires a task writes the fired entry
// back and then reads every stored entry once from the task RAM, one per
// cycle, through a two-stage slack and compare pipeline that picks the next
// task to check.
// One request is worked on at a time; the result register lets the next
// request in while a result waits to be taken.
module periodic_task_scheduler_core
    import pts_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] period_ms, [63:32] now_ms
    input  logic [0:0]  i_s_tuser,   // [0] action (0 add, 1 tick)
    // Result channel.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] accepted, [1] fire, [4:2] task_index, [7:5] zero
);

    localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    // Control registers.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_sel;
    logic [CNT_W-1:0]  r_ptr;
    logic              r_v1, r_v2;
    logic              r_out_valid;

    // Payload registers.
    logic [31:0]       r_now;
    logic [ADDR_W-1:0] r_tsel;
    logic [ADDR_W-1:0] r_i1, r_i2, r_best;
    logic [31:0]       r_slack, r_best_slack;
    logic              r_res_acc, r_res_fire;
    logic [2:0]        r_res_idx;
    logic [7:0]        r_out_data;

    // RAM ports.
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

    logic              s_acc, is_add, is_tick, room, due, scan_rd, scan_done, out_load;
    logic [ADDR_W-1:0] sel_eff;
    logic [31:0]       rd_period, rd_last, age;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign is_add   = (i_s_tuser[0] == ACT_ADD);
    assign is_tick  = (i_s_tuser[0] == ACT_TICK);
    assign room     = (r_count < MAX_CNT);
    assign sel_eff  = (CNT_W'(r_sel) >= r_count) ? '0 : r_sel;

    assign rd_period = mem_rdata[63:32];
    assign rd_last   = mem_rdata[31:0];
    assign age       = r_now - rd_last;
    assign due       = (age >= rd_period);

    assign scan_rd   = (r_state == S_SCAN) && (r_ptr < r_count);
    assign scan_done = (r_state == S_SCAN) && (r_ptr == r_count) && !r_v1 && !r_v2;
    assign out_load  = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // RAM access: add writes the new entry, a firing check writes back the
    // fired entry; reads come from the tick accept and from the scan.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[ADDR_W-1:0];
        mem_wdata = {i_s_tdata[31:0], INITIAL_LAST_MS};
        if (s_acc && is_add && room) begin
            mem_we = 1'b1;
        end else if ((r_state == S_CHECK) && due) begin
            mem_we    = 1'b1;
            mem_waddr = r_tsel;
            mem_wdata = {rd_period, r_now};
        end
        mem_re    = (s_acc && is_tick && (r_count != '0)) || scan_rd;
        mem_raddr = (r_state == S_IDLE) ? sel_eff : r_ptr[ADDR_W-1:0];
    end

    pts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (is_tick && (r_count != '0)) ? S_CHECK : S_EMIT;
                end
            end
            S_CHECK: begin
                n_state = due ? S_SCAN : S_EMIT;
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sel       <= '0;
            r_ptr       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc && is_add && room) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_CHECK) begin
                r_ptr <= '0;
            end else if (scan_rd) begin
                r_ptr <= r_ptr + 1'b1;
            end
            r_v1 <= scan_rd;
            r_v2 <= r_v1;
            if (scan_done) begin
                r_sel <= r_best;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result fields.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_now      <= i_s_tdata[63:32];
            r_tsel     <= sel_eff;
            r_res_fire <= 1'b0;
            r_res_acc  <= is_add && room;
            r_res_idx  <= (is_add && room) ? 3'(r_count) : 3'd0;
        end
        if (r_state == S_CHECK) begin
            r_res_fire <= due;
            r_res_idx  <= due ? 3'(r_tsel) : 3'd0;
        end
        if (out_load) begin
            r_out_data <= {3'b000, r_res_idx, r_res_fire, r_res_acc};
        end
    end

    // Scan pipeline: slack of each entry, then the running minimum.
    always_ff @(posedge i_clk) begin
        r_i1    <= r_ptr[ADDR_W-1:0];
        r_i2    <= r_i1;
        r_slack <= (rd_period + SAFETY_MARGIN_MS) - age;
        if (r_v2 && ((r_i2 == '0) || (r_slack < r_best_slack))) begin
            r_best       <= r_i2;
            r_best_slack <= r_slack;
        end
    end

    // The task count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("task count exceeds table size");

    // Whenever the table is not empty, the selected task is a stored one.
    a_sel_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CNT_W'(r_sel) < r_count))
        else $error("selected task is not stored");

    // An add with room grows the table by exactly one.
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_add && room) |=> (r_count == $past(r_count) + 1'b1))
        else $error("add did not store a task");

    // A result never reports both an added and a fired task.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("result marks both accepted and fire");

    // The scan only runs after a firing check.
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SCAN) |-> ($past(r_state) == S_CHECK))
        else $error("scan entered without a fired task");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler core testbench
// Streams add and tick requests into the core and checks every result
// against a cycle-free prediction of the task table and the task selection.
// A directed opening covers the empty table, the not-due tick, the full
// table and the 32-bit time wrap. After that, mostly forward-moving time
// ticks fire the stored tasks over and over, with random time jumps and
// refused adds mixed in. Both sides of the core stall at random.
// ----------------------------------------------------------------------------
module testbench
    import pts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_SLOTS  = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_REQUESTS = 930;
    localparam int REPORT_CAP = 200;

    // One input request as the core sees it.
    typedef struct packed {
        logic        action;
        logic [31:0] period;
        logic [31:0] now;
    } t_request;

    // One result as the core should return it.
    typedef struct packed {
        logic       accepted;
        logic       fire;
        logic [2:0] task_index;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;   // [31:0] period_ms, [63:32] now_ms
    logic [0:0]  i_s_tuser = '0;   // [0] action (0 add, 1 tick)
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [0] accepted, [1] fire, [4:2] task_index, [7:5] zero

    // Predicted state of the task table.
    logic [31:0] sched_period [TASK_SLOTS];
    logic [31:0] sched_last   [TASK_SLOTS];
    int          sched_count = 0;
    int          sched_sel   = 0;

    t_request request_queue [$];
    t_result  pending_results [$];
    t_request cur_req;
    t_result  want;

    int  n_sent = 0;
    int  n_fail = 0;
    int  n_added = 0;
    int  n_refused = 0;
    int  n_fired = 0;
    int  n_quiet = 0;
    int  stall_cycles = 0;
    logic calm;

    logic [31:0] clock_ms;
    int          pick;

    periodic_task_scheduler_core #(
        .MAX_TASKS(TASK_SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // A stretch of requests during which neither side stalls.
    assign calm = (n_sent >= 400) && (n_sent < 560);

    // Wrapped distance to the next firing of one task, margin included.
    function automatic logic [31:0] task_slack(int idx, logic [31:0] now);
        logic [31:0] slack;
        slack = (sched_period[idx] + SAFETY_MARGIN_MS) - (now - sched_last[idx]);
        return slack;
    endfunction

    // Apply one request to the predicted table and return its result.
    function automatic t_result schedule_outcome(t_request rq);
        t_result     res;
        logic [31:0] elapsed;
        logic [31:0] best_slack;
        logic [31:0] slack;
        int          best;
        int          sel;
        res = '0;
        if (rq.action == ACT_ADD) begin
            if (sched_count < TASK_SLOTS) begin
                sched_period[sched_count] = rq.period;
                sched_last[sched_count]   = INITIAL_LAST_MS;
                res.accepted   = 1'b1;
                res.task_index = sched_count[2:0];
                sched_count++;
                n_added++;
            end else begin
                n_refused++;
            end
        end else if (sched_count != 0) begin
            sel = (sched_sel < sched_count) ? sched_sel : 0;
            elapsed = rq.now - sched_last[sel];
            if (elapsed >= sched_period[sel]) begin
                sched_last[sel] = rq.now;
                res.fire        = 1'b1;
                res.task_index  = sel[2:0];
                // Pick the task with the least slack, the lowest index on ties.
                best = 0;
                best_slack = task_slack(0, rq.now);
                for (int i = 1; i < sched_count; i++) begin
                    slack = task_slack(i, rq.now);
                    if (slack < best_slack) begin
                        best_slack = slack;
                        best = i;
                    end
                end
                sched_sel = best;
                n_fired++;
            end else begin
                n_quiet++;
            end
        end else begin
            n_quiet++;
        end
        return res;
    endfunction

    function automatic void queue_add(logic [31:0] period);
        t_request rq;
        rq.action = ACT_ADD;
        rq.period = period;
        rq.now    = $urandom;
        request_queue.push_back(rq);
    endfunction

    function automatic void queue_tick(logic [31:0] now);
        t_request rq;
        rq.action = ACT_TICK;
        rq.period = $urandom;
        rq.now    = now;
        request_queue.push_back(rq);
    endfunction

    task automatic check_field(input string label, input int expected, input int actual);
        if (expected != actual) begin
            n_fail++;
            if (n_fail <= REPORT_CAP) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, label, expected, actual);
            end
        end
    endtask

    // Request driver: presents the next pending request, predicts on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(schedule_outcome(cur_req));
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (request_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                    cur_req = request_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {cur_req.now, cur_req.period};
                    i_s_tuser  <= cur_req.action;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and a check of every result taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= REPORT_CAP) begin
                        $display("%0t ns: result with nothing expected, expected none, actual %b",
                                 $time, o_m_tdata);
                    end
                end else begin
                    want = pending_results.pop_front();
                    check_field("accepted", want.accepted, o_m_tdata[0]);
                    check_field("fire", want.fire, o_m_tdata[1]);
                    check_field("task_index", want.task_index, o_m_tdata[4:2]);
                    check_field("padding", 0, o_m_tdata[7:5]);
                end
            end
            i_m_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", stall_cycles);
            $display("periodic_task_scheduler_core verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // Directed opening: ticks on an empty table.
        queue_tick(32'h0000_0000);
        queue_tick(32'hFFFF_FFFF);
        // One task, a tick before it is due and one exactly at its period.
        queue_add(32'd1000);
        queue_tick(32'd999);
        queue_tick(32'd1000);
        // Fill the table, period extremes included.
        queue_add(32'd0);
        queue_add(32'hFFFF_FFFF);
        queue_add(32'd1);
        queue_add(32'd10);
        queue_add(32'd100);
        queue_add(32'd50000);
        queue_add(32'd7);
        // Adds on a full table are refused.
        queue_add(32'h1234_5678);
        queue_add(32'hFFFF_FFFF);
        // Not-due tick on the refreshed task, then ticks across the time wrap.
        queue_tick(32'd1000);
        queue_tick(32'd2000);
        queue_tick(32'd2001);
        queue_tick(32'd2002);
        queue_tick(32'd2500);
        queue_tick(32'd60000);
        queue_tick(32'h7FFF_FFFF);
        queue_tick(32'hFFFF_FFFF);
        queue_tick(32'h0000_0000);
        queue_tick(32'h0000_0005);
        queue_tick(32'h8000_0000);

        // Random part: mostly time moving forward, with jumps and refused adds.
        clock_ms = 32'h8000_0000;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_add($urandom);
            end else if (pick < 16) begin
                clock_ms = $urandom;
                queue_tick(clock_ms);
            end else if (pick < 24) begin
                clock_ms = clock_ms + $urandom_range(0, 200000);
                queue_tick(clock_ms);
            end else begin
                clock_ms = clock_ms + $urandom_range(0, 3000);
                queue_tick(clock_ms);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || i_s_tvalid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d adds stored, %0d adds refused on a full table,",
                 n_sent, n_added, n_refused);
        $display("%0d ticks fired a task, %0d ticks fired nothing; %0d mismatches.",
                 n_fired, n_quiet, n_fail + pending_results.size());
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("periodic_task_scheduler_core verification clean");
        end else begin
            $display("periodic_task_scheduler_core verification failed");
        end
        $finish;
    end

endmodule
